@@ src/chtu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtu_pkg: shared types and constants of the cuckoo hash table unit
// Key and index widths, status codes, transaction payloads and the queue item.
// ----------------------------------------------------------------------------
package chtu_pkg;

  localparam int KEY_W       = 32;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ROUNDS_W    = 6;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = ROUNDS_W'(10);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    CLS_ZERO   = 2'd0,
    CLS_INSERT = 2'd1,
    CLS_LOOKUP = 2'd2
  } cls_t;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found_table;
    logic [KEY_W-1:0] homeless_key;
  } rsp_t;

  typedef struct packed {
    cls_t             cls;
    logic [KEY_W-1:0] key;
  } item_t;

  function automatic logic [IDX_W-1:0] idx0(input logic [KEY_W-1:0] k);
    return k[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx1(input logic [KEY_W-1:0] k);
    return k[2*IDX_W-1:IDX_W];
  endfunction

endpackage

@@ src/chtu_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtu_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module chtu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/chtu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtu_front: request intake and classification
// Accepts request transactions, sorts them into zero-key, insert and lookup
// work, and holds them in a two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module chtu_front import chtu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  req_t  req,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      cls_item;

  always_comb begin
    cls_item.key = req.key;
    if (req.key == '0) begin
      cls_item.cls = CLS_ZERO;
    end else if (req.opcode == OP_INSERT) begin
      cls_item.cls = CLS_INSERT;
    end else begin
      cls_item.cls = CLS_LOOKUP;
    end
  end

  assign req_ready = (count != 2'd2);
  assign q_valid   = (count != 2'd0);
  assign q_item    = slots[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/chtu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtu_back: cuckoo table engine
// Runs inserts as a chain of table kicks and lookups as a dual probe over the
// two table RAMs, answers zero keys directly, and holds the response in an
// output register.
module chtu_back import chtu_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ROUNDS_W-1:0] cfg_wdata,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rsp_t                rsp
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_KICK   = 4'b0010,
    S_PROBE  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [ROUNDS_W-1:0] max_rounds;
  logic [KEY_W-1:0]    carried, carried_next;
  logic                tbl, tbl_next;
  logic [IDX_W-1:0]    addr, addr_next;
  logic [ROUNDS_W-1:0] round, round_next;
  rsp_t                res, res_next;

  logic [TABLE_DEPTH-1:0] valid0, valid1;
  logic                   vq0, vq1;
  logic                   we0, we1;
  logic [IDX_W-1:0]       raddr0, raddr1;
  logic [KEY_W-1:0]       rdata0, rdata1;
  logic [KEY_W-1:0]       occ;
  logic [IDX_W-1:0]       naddr;
  logic                   can_load;

  chtu_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_ram0 (
    .clk  (clk),
    .we   (we0),
    .waddr(addr),
    .wdata(carried),
    .raddr(raddr0),
    .rdata(rdata0)
  );

  chtu_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_ram1 (
    .clk  (clk),
    .we   (we1),
    .waddr(addr),
    .wdata(carried),
    .raddr(raddr1),
    .rdata(rdata1)
  );

  assign can_load = !rsp_valid || rsp_ready;

  always_comb begin
    if (tbl) begin
      occ = vq1 ? rdata1 : '0;
    end else begin
      occ = vq0 ? rdata0 : '0;
    end
    naddr = tbl ? idx0(occ) : idx1(occ);
  end

  always_comb begin
    state_next   = state;
    carried_next = carried;
    tbl_next     = tbl;
    addr_next    = addr;
    round_next   = round;
    res_next     = res;
    q_pop        = 1'b0;
    we0          = 1'b0;
    we1          = 1'b0;
    raddr0       = idx0(q_item.key);
    raddr1       = idx1(q_item.key);
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          carried_next = q_item.key;
          tbl_next     = 1'b0;
          addr_next    = idx0(q_item.key);
          round_next   = '0;
          res_next     = '0;
          case (q_item.cls)
            CLS_ZERO: begin
              res_next.status = ST_ZERO;
              state_next      = S_RESULT;
            end
            CLS_INSERT: begin
              if (max_rounds == '0) begin
                res_next.status       = ST_FAIL;
                res_next.homeless_key = q_item.key;
                state_next            = S_RESULT;
              end else begin
                state_next = S_KICK;
              end
            end
            default: begin
              state_next = S_PROBE;
            end
          endcase
        end
      end
      S_KICK: begin
        we0 = !tbl;
        we1 = tbl;
        if (occ == '0) begin
          res_next.status = ST_OK;
          state_next      = S_RESULT;
        end else if (tbl && (round + ROUNDS_W'(1) == max_rounds)) begin
          res_next.status       = ST_FAIL;
          res_next.homeless_key = occ;
          state_next            = S_RESULT;
        end else begin
          carried_next = occ;
          tbl_next     = ~tbl;
          addr_next    = naddr;
          if (tbl) begin
            round_next = round + ROUNDS_W'(1);
          end
          raddr0 = naddr;
          raddr1 = naddr;
        end
      end
      S_PROBE: begin
        if (vq0 && (rdata0 == carried)) begin
          res_next.status = ST_OK;
        end else if (vq1 && (rdata1 == carried)) begin
          res_next.status      = ST_OK;
          res_next.found_table = 1'b1;
        end else begin
          res_next.status = ST_FAIL;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      max_rounds <= ROUNDS_RESET;
      valid0     <= '0;
      valid1     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        max_rounds <= cfg_wdata;
      end
      if (we0) begin
        valid0[addr] <= 1'b1;
      end
      if (we1) begin
        valid1[addr] <= 1'b1;
      end
      if (state == S_RESULT && can_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    carried <= carried_next;
    tbl     <= tbl_next;
    addr    <= addr_next;
    round   <= round_next;
    res     <= res_next;
    vq0     <= valid0[raddr0];
    vq1     <= valid1[raddr1];
    if (state == S_RESULT && can_load) begin
      rsp <= res;
    end
  end

endmodule

@@ src/cuckoo_hash_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuckoo_hash_table_unit: two-table cuckoo hash set of 32-bit keys
// Request transactions carry an opcode (insert or lookup) and a key; each one
// produces exactly one response transaction with status, found_table and
// homeless_key. Key zero is the empty marker and is answered with status 2.
// Table 0 is indexed by key mod 16, table 1 by (key div 16) mod 16.
// max_rounds is written through cfg_we/cfg_wdata; the user must write it
// only while the unit is idle, as the block itself does not enforce this.
// A two-entry queue decouples request intake from the table engine, so new
// requests are taken while the engine works or a response waits. The
// engine kicks one table per cycle, alternating between the two table RAMs,
// until a kick finds an empty slot or max_rounds rounds are spent, and
// handles one request at a time, so it takes a new request only after the
// previous response is loaded into its register.
// Reset clears the queue, the response valid flag and the slot valid bits, so
// both tables read as empty at once, and sets max_rounds to 10.
// When the receiver holds rsp_ready low the response stays in its register,
// the engine waits, and requests keep queuing until the queue is full.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_unit import chtu_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  req_t                req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rsp_t                rsp,
  input  logic                cfg_we,
  input  logic [ROUNDS_W-1:0] cfg_wdata
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  chtu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  chtu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_FAIL || rsp.status == ST_ZERO))
    else $error("response carries an undefined status code");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.found_table) |-> (rsp.status == ST_OK))
    else $error("found_table set on a response that is not a hit");

  a_homeless_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.homeless_key != '0) |-> (rsp.status == ST_FAIL))
    else $error("homeless_key set on a response that is not a failed insert");

  a_zero_key: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_ZERO) |-> (!rsp.found_table && rsp.homeless_key == '0))
    else $error("rejected key response carries table or homeless data");

endmodule

@@ tb/chtu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtu_checker: response predictor and scoreboard for the cuckoo hash table
// Watches the request, response and max_rounds write ports, keeps its own
// copy of both hash tables, and compares every response transaction field by
// field with the oldest predicted answer. Mismatches are counted and handed
// to the testbench top together with the number of answers still awaited.
// ----------------------------------------------------------------------------
module chtu_checker import chtu_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  req_t                req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  rsp_t                rsp,
  input  logic                cfg_we,
  input  logic [ROUNDS_W-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  outstanding
);

  logic [KEY_W-1:0]    slot_words [2*TABLE_DEPTH];
  logic [ROUNDS_W-1:0] rounds_limit;
  rsp_t                expected_answers [$];
  int                  fail_total = 0;

  assign mismatches = fail_total;

  task automatic flag_mismatch(input string what);
    if (fail_total < 100) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_total++;
  endtask

  function automatic int home_slot(input int t, input logic [KEY_W-1:0] k);
    if (t == 0) begin
      return int'(k % TABLE_DEPTH);
    end
    return TABLE_DEPTH + int'((k / TABLE_DEPTH) % TABLE_DEPTH);
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t             res;
    logic [KEY_W-1:0] carried;
    logic [KEY_W-1:0] occupant;
    int               slot;
    bit               placed;
    res.status       = ST_FAIL;
    res.found_table  = 1'b0;
    res.homeless_key = '0;
    if (r.key == '0) begin
      res.status = ST_ZERO;
    end else if (r.opcode == OP_INSERT) begin
      carried = r.key;
      placed  = 1'b0;
      for (int rnd = 0; rnd < int'(rounds_limit) && !placed; rnd++) begin
        for (int t = 0; t < 2 && !placed; t++) begin
          slot             = home_slot(t, carried);
          occupant         = slot_words[slot];
          slot_words[slot] = carried;
          if (occupant == '0) begin
            placed = 1'b1;
          end else begin
            carried = occupant;
          end
        end
      end
      if (placed) begin
        res.status = ST_OK;
      end else begin
        res.homeless_key = carried;
      end
    end else if (slot_words[home_slot(0, r.key)] == r.key) begin
      res.status = ST_OK;
    end else if (slot_words[home_slot(1, r.key)] == r.key) begin
      res.status      = ST_OK;
      res.found_table = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      foreach (slot_words[i]) slot_words[i] = '0;
      rounds_limit = ROUNDS_RESET;
      expected_answers.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_answers.size() == 0) begin
          flag_mismatch("response transaction with no request outstanding");
        end else begin
          want = expected_answers.pop_front();
          if (rsp.status !== want.status) begin
            flag_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          end
          if (rsp.found_table !== want.found_table) begin
            flag_mismatch($sformatf("found_table %0d, expected %0d",
                                    rsp.found_table, want.found_table));
          end
          if (rsp.homeless_key !== want.homeless_key) begin
            flag_mismatch($sformatf("homeless_key %h, expected %h",
                                    rsp.homeless_key, want.homeless_key));
          end
        end
      end
      if (req_valid && req_ready) begin
        expected_answers.push_back(apply_request(req));
      end
      if (cfg_we) begin
        rounds_limit = cfg_wdata;
      end
    end
    outstanding <= expected_answers.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the cuckoo hash table unit
// Drives a directed opening (key zero, extreme keys, eviction chains, zero,
// one and maximum round limits) and then random insert and lookup traffic
// over several max_rounds settings, with random idle bursts on both sides and
// one long response stall. A separate checker predicts and scores responses.
// ----------------------------------------------------------------------------
module testbench;
  import chtu_pkg::*;

  localparam int LIMIT           = 1_500_000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_ready;
  req_t                req;
  logic                rsp_valid;
  logic                rsp_ready;
  rsp_t                rsp;
  logic                cfg_we;
  logic [ROUNDS_W-1:0] cfg_wdata;

  int               mismatches;
  int               outstanding;
  int               cycle_count = 0;
  int               sent_count = 0;
  bit               quiet = 1'b0;
  bit               sender_lazy = 1'b0;
  logic [KEY_W-1:0] inserted_keys [$];
  logic [7:0]       hot_bytes [4] = '{8'h00, 8'h01, 8'h10, 8'h11};

  cuckoo_hash_table_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  chtu_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("cuckoo_hash_table_unit regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [KEY_W-1:0] k);
    int gap;
    gap = 0;
    if (!quiet && sender_lazy && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 5);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{opcode: op, key: k};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_count++;
    if (op == OP_INSERT) begin
      inserted_keys.push_back(k);
      if (inserted_keys.size() > 64) begin
        void'(inserted_keys.pop_front());
      end
    end
  endtask

  task automatic send_random();
    int               pick;
    logic             op;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(0, 99);
    op   = 1'($urandom_range(0, 1));
    k    = $urandom();
    if (pick < 5) begin
      k = '0;
    end else if (pick >= 15 && pick < 55 && inserted_keys.size() > 0) begin
      op = OP_LOOKUP;
      k  = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    end else if (pick >= 15) begin
      op = OP_INSERT;
      if ($urandom_range(0, 1) == 1) begin
        k[7:0] = hot_bytes[$urandom_range(0, 3)];
      end
    end
    send_item(op, k);
  endtask

  task automatic set_rounds(input logic [ROUNDS_W-1:0] value);
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : receiver
    bit squeezed;
    bit lazy;
    int window;
    squeezed = 1'b0;
    lazy     = 1'b0;
    window   = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        lazy   = 1'($urandom_range(0, 1));
        window = $urandom_range(20, 100);
      end
      window--;
      if (!squeezed && sent_count >= 300) begin
        squeezed = 1'b1;
        rsp_ready <= 1'b0;
        repeat (200) @(posedge clk);
        rsp_ready <= 1'b1;
      end else if (!quiet && !rst && lazy && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int plan [PHASES] = '{10, 63, 2, 1, -1, -1, 10, 63};
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_LOOKUP, '0);
    send_item(OP_INSERT, '0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_000F);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'h0000_000F);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'hA5A5_A5A5);
    send_item(OP_INSERT, 32'h5A5A_5A5A);
    send_item(OP_INSERT, 32'h0000_0001);
    send_item(OP_LOOKUP, 32'h5A5A_5A5A);
    set_rounds('0);
    send_item(OP_INSERT, 32'h1234_5678);
    send_item(OP_LOOKUP, 32'h1234_5678);
    send_item(OP_INSERT, '0);
    set_rounds(ROUNDS_W'(1));
    send_item(OP_INSERT, 32'h0000_0100);
    send_item(OP_INSERT, 32'h0000_0200);
    send_item(OP_LOOKUP, 32'h8000_0000);
    set_rounds(ROUNDS_W'(63));
    send_item(OP_INSERT, 32'h0000_0300);
    send_item(OP_INSERT, 32'h0000_0400);
    send_item(OP_LOOKUP, 32'h0000_0100);

    for (int p = 0; p < PHASES; p++) begin
      if (plan[p] < 0) begin
        set_rounds(ROUNDS_W'($urandom_range(3, 62)));
      end else begin
        set_rounds(ROUNDS_W'(plan[p]));
      end
      if (p == PHASES - 1) begin
        quiet = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 40 == 0) begin
          sender_lazy = 1'($urandom_range(0, 1));
        end
        send_random();
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (mismatches == 0) begin
      $display("cuckoo_hash_table_unit regression: pass");
    end else begin
      $display("cuckoo_hash_table_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/chtu_pkg.sv
src/chtu_ram.sv
src/chtu_front.sv
src/chtu_back.sv
src/cuckoo_hash_table_unit.sv
tb/chtu_checker.sv
tb/testbench.sv
